// File: rtl/core/four_level_page_table_walker_assert.svh
// ----------------------------------------------------------------------------
// four_level_page_table_walker_assert.svh
// assertion macros for the page table walker, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define FLPTW_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("page table walker assertion failed");
// next-cycle implication
`define FLPTW_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("page table walker assertion failed");
`else
`define FLPTW_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define FLPTW_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// File: rtl/core/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// shared types and constants of the four-level page table walker
// ----------------------------------------------------------------------------
package flptw_pkg;

	// store geometry
	localparam int TABLE_PAGES = 64;
	localparam int STORE_WORDS = TABLE_PAGES * 512;
	localparam int ADDR_W      = $clog2(STORE_WORDS);

	// entry bits and masks
	localparam logic [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] BIT_P      = 64'h0000_0000_0000_0001;
	localparam logic [63:0] BIT_W      = 64'h0000_0000_0000_0002;
	localparam logic [63:0] BIT_U      = 64'h0000_0000_0000_0004;
	localparam logic [63:0] BIT_PS     = 64'h0000_0000_0000_0080;
	localparam logic [63:0] BIT_NX     = 64'h8000_0000_0000_0000;
	localparam logic [1:0]  LAST_LEVEL = 2'd3;

	// configuration register indexes
	localparam logic CFG_ROOT  = 1'b0;
	localparam logic CFG_SPACE = 1'b1;

	// transaction kinds
	typedef enum logic [2:0] {
		KIND_WRITE     = 3'd0,
		KIND_READ      = 3'd1,
		KIND_TRANSLATE = 3'd2,
		KIND_UNMAP     = 3'd3,
		KIND_PROTECT   = 3'd4,
		KIND_DEBUG     = 3'd5
	} kind_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic clear_wr;
		logic word_wr;
		logic word_rd;
		logic walk_start;
		logic walk_rd;
		logic walk_take;
		logic leaf_wr;
		logic res_load;
		logic res_fault;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  clr_last;
		logic  widx_ok;
		logic  pre_ok;
		logic  base_ok;
		logic  entry_ok;
		logic  last_lvl;
	} stat_t;

endpackage

// File: rtl/core/flptw_datapath.sv
// ----------------------------------------------------------------------------
// flptw_datapath
// table store, walk registers, configuration and result registers
// ----------------------------------------------------------------------------
module flptw_datapath import flptw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [2:0]  kind,
	input  logic [63:0] virt_addr,
	input  logic [14:0] word_index,
	input  logic [63:0] data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [51:0] cfg_data,
	output logic        status,
	output logic [51:0] phys_addr,
	output logic [63:0] entry
);

	logic [63:0]       mem [STORE_WORDS];
	logic [63:0]       rdata_q;
	logic [2:0]        kind_q;
	logic [63:0]       va_q;
	logic [14:0]       widx_q;
	logic [63:0]       data_q;
	logic [51:0]       root_q;
	logic              space_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [51:0]       tab_q;
	logic [1:0]        lvl_q;
	logic [7:0]        elo_q [3];
	logic              status_q;
	logic [51:0]       phys_q;
	logic [63:0]       entry_q;

	logic [8:0]        va_idx;
	logic [ADDR_W-1:0] pos;
	logic [ADDR_W-1:0] widx_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [63:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [63:0]       leaf_addr;
	logic [63:0]       prot_val;
	logic              res_status;
	logic [51:0]       res_phys;
	logic [63:0]       res_entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			space_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROOT:  root_q  <= cfg_data;
				CFG_SPACE: space_q <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			va_q   <= virt_addr;
			widx_q <= word_index;
			data_q <= data;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// table index of the current level
	always_comb begin
		case (lvl_q)
			2'd0:    va_idx = va_q[47:39];
			2'd1:    va_idx = va_q[38:30];
			2'd2:    va_idx = va_q[29:21];
			default: va_idx = va_q[20:12];
		endcase
	end

	assign pos       = ADDR_W'({tab_q[51:12], va_idx});
	assign widx_addr = ADDR_W'(widx_q);

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			tab_q <= root_q;
			lvl_q <= 2'd0;
		end else if (cmd.walk_take) begin
			tab_q        <= rdata_q[51:0] & ADDR_MASK[51:0];
			lvl_q        <= lvl_q + 2'd1;
			elo_q[lvl_q] <= rdata_q[7:0];
		end
	end

	// new leaf for protect
	assign leaf_addr = rdata_q & ADDR_MASK;
	assign prot_val  = leaf_addr | BIT_P | BIT_U | (data_q & (BIT_W | BIT_NX));

	// store port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos;
		mem_wdata = '0;
		if (cmd.clear_wr) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (cmd.word_wr) begin
			mem_we    = st.widx_ok;
			mem_waddr = widx_addr;
			mem_wdata = data_q;
		end else if (cmd.leaf_wr) begin
			mem_we    = 1'b1;
			mem_wdata = (kind_q == KIND_PROTECT) ? prot_val : 64'd0;
		end
	end

	assign mem_re    = cmd.word_rd | cmd.walk_rd;
	assign mem_raddr = cmd.word_rd ? widx_addr : pos;

	// table store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// status towards the controller
	always_comb begin
		st.kind     = kind_t'(kind_q);
		st.clr_last = clr_addr_q == ADDR_W'(STORE_WORDS - 1);
		st.widx_ok  = {17'd0, widx_q} < 32'(STORE_WORDS);
		st.pre_ok   = space_q && (va_q[63:47] == 17'd0) &&
			((va_q[11:0] == 12'd0) || (kind_q == KIND_TRANSLATE));
		st.base_ok  = (tab_q != 52'd0) && (tab_q[11:0] == 12'd0) &&
			(tab_q[51:12] < 40'(TABLE_PAGES));
		st.entry_ok = rdata_q[0] && ((lvl_q == LAST_LEVEL) || !rdata_q[7]);
		st.last_lvl = lvl_q == LAST_LEVEL;
	end

	// result formation by kind
	always_comb begin
		res_status = 1'b0;
		res_phys   = '0;
		res_entry  = '0;
		case (kind_q)
			KIND_WRITE: ;
			KIND_READ:  res_entry = rdata_q;
			KIND_TRANSLATE: begin
				res_phys  = leaf_addr[51:0] | {40'd0, va_q[11:0]};
				res_entry = rdata_q;
			end
			KIND_UNMAP: begin
				res_phys  = leaf_addr[51:0];
				res_entry = rdata_q;
			end
			KIND_PROTECT: begin
				res_phys  = leaf_addr[51:0];
				res_entry = prot_val;
			end
			KIND_DEBUG: res_entry = {32'd0, rdata_q[7:0], elo_q[2], elo_q[1], elo_q[0]};
			default:    res_status = 1'b1;
		endcase
		if (cmd.res_fault) begin
			res_status = 1'b1;
			res_phys   = '0;
			res_entry  = '0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= res_status;
			phys_q   <= res_phys;
			entry_q  <= res_entry;
		end
	end

	assign status    = status_q;
	assign phys_addr = phys_q;
	assign entry     = entry_q;

endmodule

// File: rtl/core/flptw_ctrl.sv
// ----------------------------------------------------------------------------
// flptw_ctrl
// sequencer for store clearing, word access and the four-level walk
// ----------------------------------------------------------------------------
module flptw_ctrl import flptw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	output cmd_t  cmd,
	input  stat_t st
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_WORD_DATA,
		S_WALK_RD,
		S_WALK_CHK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				case (st.kind)
					KIND_WRITE: begin
						cmd.word_wr  = 1'b1;
						cmd.res_load = 1'b1;
					end
					KIND_READ: begin
						if (st.widx_ok) begin
							cmd.word_rd = 1'b1;
							state_d     = S_WORD_DATA;
						end else begin
							cmd.res_load  = 1'b1;
							cmd.res_fault = 1'b1;
						end
					end
					KIND_TRANSLATE, KIND_UNMAP, KIND_PROTECT, KIND_DEBUG: begin
						if (st.pre_ok) begin
							cmd.walk_start = 1'b1;
							state_d        = S_WALK_RD;
						end else begin
							cmd.res_load  = 1'b1;
							cmd.res_fault = 1'b1;
						end
					end
					default: begin
						cmd.res_load  = 1'b1;
						cmd.res_fault = 1'b1;
					end
				endcase
			end
			S_WORD_DATA: begin
				cmd.res_load = 1'b1;
				state_d      = S_IDLE;
			end
			S_WALK_RD: begin
				if (st.base_ok) begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_CHK;
				end else begin
					cmd.res_load  = 1'b1;
					cmd.res_fault = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_WALK_CHK: begin
				if (!st.entry_ok) begin
					cmd.res_load  = 1'b1;
					cmd.res_fault = 1'b1;
					state_d       = S_IDLE;
				end else if (st.last_lvl) begin
					cmd.res_load = 1'b1;
					cmd.leaf_wr  = (st.kind == KIND_UNMAP) || (st.kind == KIND_PROTECT);
					state_d      = S_IDLE;
				end else begin
					cmd.walk_take = 1'b1;
					state_d       = S_WALK_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.res_load;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

// File: rtl/core/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// four-level 512-entry page table walker over an internal table store
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         start & !busy      kind, virt_addr, word_index, data
// result    out        done (one cycle)   status, phys_addr, entry
// config    in         cfg_we             cfg_index, cfg_data
//
// a transaction runs through capture and dispatch; a word read adds a data step,
// and a walk adds a table read and an entry check per level, ending early on a
// fault, through the table store; write-back shares the last check.
// after reset a clearing pass zeroes all 32768 words of the store, one word a
// cycle, with busy high; config writes are taken during it.
// results cannot be stalled; a new request is taken in the done cycle.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker import flptw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [63:0] virt_addr,
	input  logic [14:0] word_index,
	input  logic [63:0] data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [51:0] cfg_data,
	output logic        done,
	output logic        status,
	output logic [51:0] phys_addr,
	output logic [63:0] entry
);

	cmd_t  cmd;
	stat_t st;

	// sequencer
	flptw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.st     (st)
	);

	// store and datapath
	flptw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.kind       (kind),
		.virt_addr  (virt_addr),
		.word_index (word_index),
		.data       (data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.status     (status),
		.phys_addr  (phys_addr),
		.entry      (entry)
	);

	// an accepted transaction occupies the sequencer
	`FLPTW_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// results appear only once the sequencer is free
	`FLPTW_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	// one strobe per transaction
	`FLPTW_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule

// File: tb/tb_four_level_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker
// self-checking bench for the four-level page table walker
//
// Loads page tables through write-word transactions, then walks them with
// translate, unmap, protect and debug transactions under several root table
// and address space settings. A predictor keeps its own copy of the table
// store and the registers. Every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker;
	import flptw_pkg::*;

	localparam logic [2:0]  KIND_SPARE_LO  = 3'd6;
	localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
	localparam logic [63:0] USER_LIMIT     = 64'h0000_8000_0000_0000;
	localparam logic [63:0] PAGE_OFFSET    = 64'h0000_0000_0000_0FFF;
	localparam logic [63:0] IDX_MASK       = 64'h0000_0000_0000_01FF;
	localparam logic [51:0] ROOT_DIRECTED  = 52'h0_0000_0000_1000;
	localparam int          CYCLE_LIMIT    = 400000;
	localparam int          DRAIN_CYCLES   = 12;
	localparam int          PHASES         = 8;
	localparam int          PRESSURE_PHASE = 3;
	localparam int          POOL_DEPTH     = 32;
	// page 1 indexes 1, 2, 3, 4 at the four levels
	localparam logic [63:0] DIRECTED_VA    = {17'h0, 8'd1, 9'd2, 9'd3, 9'd4, 12'h0};

	typedef struct packed {
		logic        status;
		logic [51:0] phys;
		logic [63:0] entry;
	} walk_result_t;

	// predictor of the walker plus the queue of results still to come
	class walk_result_board;
		bit [63:0]    table_mirror [STORE_WORDS];
		logic [51:0]  root_addr;
		bit           space_on;
		walk_result_t expected_walks [$];
		int           failures;

		function new();
			root_addr = '0;
			space_on  = 1'b0;
			failures  = 0;
		endfunction

		// store word base of a table address, zero when unusable
		function bit table_base(logic [63:0] a, output int unsigned base);
			base = 0;
			if (a == 64'h0 || a[11:0] != 12'h0 || (a >> 12) >= TABLE_PAGES)
				return 1'b0;
			base = int'(a >> 12) * 512;
			return 1'b1;
		endfunction

		// four-level walk from the root, giving the leaf position and the entries met
		function bit walk_tables(logic [63:0] va, output int unsigned leaf_pos,
				output logic [3:0][63:0] ents);
			logic [63:0] tab;
			logic [63:0] e;
			int unsigned base;
			int unsigned pos;
			int lvl;
			leaf_pos = 0;
			ents = '0;
			if (!space_on || va >= USER_LIMIT)
				return 1'b0;
			tab = 64'(root_addr);
			for (lvl = 0; lvl < 4; lvl++) begin
				if (!table_base(tab, base))
					return 1'b0;
				pos = base + int'((va >> (39 - 9 * lvl)) & IDX_MASK);
				if (pos >= STORE_WORDS)
					return 1'b0;
				e = table_mirror[pos];
				ents[lvl] = e;
				if ((e & BIT_P) == 64'h0)
					return 1'b0;
				if (lvl < LAST_LEVEL && (e & BIT_PS) != 64'h0)
					return 1'b0;
				tab = e & ADDR_MASK;
				leaf_pos = pos;
			end
			return 1'b1;
		endfunction

		// accepted transaction: update the mirror and queue the expected result
		function void note_request(logic [2:0] k, logic [63:0] va, logic [14:0] widx,
				logic [63:0] d);
			walk_result_t r;
			logic [3:0][63:0] ents;
			logic [63:0] nv;
			int unsigned leaf;
			bit aligned;
			r = '0;
			r.status = 1'b1;
			aligned = (va[11:0] == 12'h0);
			case (k)
				KIND_WRITE: begin
					table_mirror[widx] = d;
					r.status = 1'b0;
				end
				KIND_READ: begin
					r.entry = table_mirror[widx];
					r.status = 1'b0;
				end
				KIND_TRANSLATE: begin
					if (walk_tables(va, leaf, ents)) begin
						r.phys   = 52'((ents[3] & ADDR_MASK) | (va & PAGE_OFFSET));
						r.entry  = ents[3];
						r.status = 1'b0;
					end
				end
				KIND_UNMAP: begin
					if (aligned && walk_tables(va, leaf, ents)) begin
						r.phys   = 52'(ents[3] & ADDR_MASK);
						r.entry  = ents[3];
						r.status = 1'b0;
						table_mirror[leaf] = 64'h0;
					end
				end
				KIND_PROTECT: begin
					if (aligned && walk_tables(va, leaf, ents)) begin
						nv = (ents[3] & ADDR_MASK) | BIT_P | BIT_U | (d & (BIT_W | BIT_NX));
						table_mirror[leaf] = nv;
						r.phys   = 52'(ents[3] & ADDR_MASK);
						r.entry  = nv;
						r.status = 1'b0;
					end
				end
				KIND_DEBUG: begin
					if (aligned && walk_tables(va, leaf, ents)) begin
						r.entry  = {32'h0, ents[3][7:0], ents[2][7:0], ents[1][7:0],
							ents[0][7:0]};
						r.status = 1'b0;
					end
				end
				default: begin
				end
			endcase
			expected_walks.push_back(r);
		endfunction

		// compare a result with the oldest expectation
		function void check_result(logic st, logic [51:0] pa, logic [63:0] en);
			walk_result_t want;
			if (expected_walks.size() == 0) begin
				$display("%0t: unexpected result: status %0b phys_addr %h entry %h",
					$time, st, pa, en);
				failures++;
				return;
			end
			want = expected_walks.pop_front();
			if (st !== want.status) begin
				$display("%0t: status mismatch: expected %0b actual %0b",
					$time, want.status, st);
				failures++;
			end
			if (pa !== want.phys) begin
				$display("%0t: phys_addr mismatch: expected %h actual %h",
					$time, want.phys, pa);
				failures++;
			end
			if (en !== want.entry) begin
				$display("%0t: entry mismatch: expected %h actual %h",
					$time, want.entry, en);
				failures++;
			end
		endfunction

		function int outstanding();
			return expected_walks.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [63:0] virt_addr;
	logic [14:0] word_index;
	logic [63:0] data;
	logic        cfg_we;
	logic        cfg_index;
	logic [51:0] cfg_data;
	logic        done;
	logic        status;
	logic [51:0] phys_addr;
	logic [63:0] entry;

	walk_result_board board;
	logic [63:0]      mapped_vas [$];
	int unsigned      sent;
	int               cycle_count;
	bit               steady;
	int               stretch_left;

	four_level_page_table_walker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.virt_addr  (virt_addr),
		.word_index (word_index),
		.data       (data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.status     (status),
		.phys_addr  (phys_addr),
		.entry      (entry)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_four_level_page_table_walker: FAIL");
			$finish;
		end
	end

	// result monitor, strobe sampled at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(status, phys_addr, entry);
	end

	// one transaction after a random gap, held until accepted
	task automatic send_item(input logic [2:0] k, input logic [63:0] va,
			input logic [14:0] widx, input logic [63:0] d);
		int unsigned gap;
		stretch_left--;
		if (stretch_left <= 0) begin
			steady = ($urandom_range(0, 3) == 0);
			stretch_left = $urandom_range(20, 60);
		end
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		kind       <= k;
		virt_addr  <= va;
		word_index <= widx;
		data       <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(k, va, widx, d);
		sent++;
	endtask

	// stop sending and wait until every result is in and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0 || busy) @(posedge clk);
	endtask

	// both registers, space word carries random spare bits
	task automatic load_config(input logic [51:0] root, input bit space_on);
		logic [51:0] space_word;
		space_word = 52'({$urandom, $urandom});
		space_word[0] = space_on;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROOT;
		cfg_data  <= root;
		@(posedge clk);
		board.root_addr = root;
		cfg_index <= CFG_SPACE;
		cfg_data  <= space_word;
		@(posedge clk);
		board.space_on = space_word[0];
		cfg_we <= 1'b0;
	endtask

	// build or reuse the path of va from the current root, fresh leaf whenever the path reaches it
	task automatic map_walk_path(input logic [63:0] va);
		logic [63:0] tab;
		logic [63:0] e;
		int unsigned base;
		int unsigned pos;
		int unsigned r;
		int lvl;
		bit stop;
		tab = 64'(board.root_addr);
		stop = 1'b0;
		for (lvl = 0; lvl < 4 && !stop; lvl++) begin
			if (!board.table_base(tab, base)) begin
				stop = 1'b1;
			end else begin
				pos = base + int'((va >> (39 - 9 * lvl)) & IDX_MASK);
				e = board.table_mirror[pos];
				if (lvl == LAST_LEVEL || (e & BIT_P) == 64'h0 || (e & BIT_PS) != 64'h0 ||
						$urandom_range(0, 3) == 0) begin
					// random flag and spare bits, present, no huge bit
					e = ({$urandom, $urandom} & ~ADDR_MASK & ~BIT_PS) | BIT_P;
					r = $urandom_range(0, 99);
					if (lvl == LAST_LEVEL) begin
						e |= {$urandom, $urandom} & ADDR_MASK;
						if (r < 8)
							e &= ~BIT_P;
						else if (r < 30)
							e |= BIT_PS;
					end else begin
						e |= 64'($urandom_range(1, TABLE_PAGES - 1)) << 12;
						// occasional broken link: huge, absent, zero or outside the store
						if (r < 4)
							e |= BIT_PS;
						else if (r < 7)
							e &= ~BIT_P;
						else if (r < 9)
							e &= ~ADDR_MASK;
						else if (r < 11)
							e = (e & ~ADDR_MASK) | ({$urandom, $urandom} & ADDR_MASK);
					end
					send_item(KIND_WRITE, {$urandom, $urandom}, 15'(pos), e);
				end
				tab = e & ADDR_MASK;
			end
		end
		mapped_vas.push_back(va);
		if (mapped_vas.size() > POOL_DEPTH)
			void'(mapped_vas.pop_front());
	endtask

	// walking transaction on a known address, or on a noisy one
	task automatic walk_op(input bit noisy);
		logic [63:0] va;
		logic [2:0]  k;
		int unsigned r;
		if (noisy || mapped_vas.size() == 0) begin
			case ($urandom_range(0, 2))
				0: va = {$urandom, $urandom};
				1: va = {$urandom, $urandom} & (USER_LIMIT - 64'h1);
				default: va = {$urandom, $urandom} | USER_LIMIT;
			endcase
		end else begin
			va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
		end
		r = $urandom_range(0, 99);
		if (r < 40)
			k = KIND_TRANSLATE;
		else if (r < 60)
			k = KIND_UNMAP;
		else if (r < 80)
			k = KIND_PROTECT;
		else
			k = KIND_DEBUG;
		if (k == KIND_TRANSLATE || $urandom_range(0, 9) == 0)
			va |= 64'($urandom_range(0, 4095));
		send_item(k, va, 15'($urandom), {$urandom, $urandom});
	endtask

	// stimulus
	initial begin
		logic [51:0] phase_roots  [PHASES];
		bit          phase_spaces [PHASES];
		int unsigned phase_items  [PHASES];
		int unsigned target;
		int unsigned r;
		int          phase;
		bit          paused;
		logic [63:0] va;

		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = KIND_WRITE;
		virt_addr  = '0;
		word_index = '0;
		data       = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_ROOT;
		cfg_data   = '0;
		sent         = 0;
		steady       = 1'b0;
		stretch_left = 0;
		paused       = 1'b0;
		board = new();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// waits out the clearing pass
		drain_results();
		load_config(ROOT_DIRECTED, 1'b0);

		// directed: top word of the store, walk with the space off
		send_item(KIND_READ, '0, 15'h7FFF, '0);
		send_item(KIND_WRITE, '0, 15'h7FFF, '1);
		send_item(KIND_READ, '0, 15'h7FFF, '0);
		send_item(KIND_TRANSLATE, DIRECTED_VA, '0, '0);
		drain_results();
		load_config(ROOT_DIRECTED, 1'b1);

		// directed path through slots 1 to 4, leaf at the top frame with huge bit
		send_item(KIND_WRITE, '0, 15'(1 * 512 + 1), (64'd2 << 12) | BIT_P | BIT_W | BIT_U);
		send_item(KIND_WRITE, '0, 15'(2 * 512 + 2), (64'd3 << 12) | BIT_P | BIT_W | BIT_U);
		send_item(KIND_WRITE, '0, 15'(3 * 512 + 3), (64'd4 << 12) | BIT_P | BIT_U);
		send_item(KIND_WRITE, '0, 15'(4 * 512 + 4),
			ADDR_MASK | BIT_P | BIT_W | BIT_PS | BIT_NX);
		send_item(KIND_TRANSLATE, DIRECTED_VA | PAGE_OFFSET, '0, '0);
		send_item(KIND_DEBUG, DIRECTED_VA, '0, '0);
		send_item(KIND_PROTECT, DIRECTED_VA, '0, '1);
		send_item(KIND_PROTECT, DIRECTED_VA, '0, '0);

		// non-user and unaligned addresses, unmap of the leaf, then spare kinds
		send_item(KIND_TRANSLATE, DIRECTED_VA | USER_LIMIT, '0, '0);
		send_item(KIND_TRANSLATE, '1, '0, '0);
		send_item(KIND_UNMAP, DIRECTED_VA | 64'h1, '0, '0);
		send_item(KIND_DEBUG, DIRECTED_VA | 64'h800, '0, '0);
		send_item(KIND_UNMAP, DIRECTED_VA, '0, '0);
		send_item(KIND_TRANSLATE, DIRECTED_VA, '0, '0);
		send_item(KIND_SPARE_LO, DIRECTED_VA, '0, '0);
		send_item(KIND_SPARE_HI, DIRECTED_VA, '0, '0);

		// broken second level: huge page, table at zero, table outside the store
		send_item(KIND_WRITE, '0, 15'(4 * 512 + 4), ADDR_MASK | BIT_P | BIT_U);
		send_item(KIND_WRITE, '0, 15'(2 * 512 + 2), (64'd3 << 12) | BIT_P | BIT_PS);
		send_item(KIND_TRANSLATE, DIRECTED_VA, '0, '0);
		send_item(KIND_WRITE, '0, 15'(2 * 512 + 2), BIT_P);
		send_item(KIND_TRANSLATE, DIRECTED_VA, '0, '0);
		send_item(KIND_WRITE, '0, 15'(2 * 512 + 2), (64'(TABLE_PAGES) << 12) | BIT_P);
		send_item(KIND_TRANSLATE, DIRECTED_VA, '0, '0);

		// register settings per phase, faulting roots get short phases
		phase_roots[0] = 52'h0_0000_0000_1000;
		phase_roots[1] = 52'(TABLE_PAGES - 1) << 12;
		phase_roots[2] = '1;
		phase_roots[3] = 52'($urandom_range(1, TABLE_PAGES - 1)) << 12;
		phase_roots[4] = '0;
		phase_roots[5] = 52'($urandom_range(1, TABLE_PAGES - 1)) << 12;
		phase_roots[6] = 52'(TABLE_PAGES) << 12;
		phase_roots[7] = 52'($urandom_range(1, TABLE_PAGES - 1)) << 12;
		phase_spaces = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		phase_items  = '{330, 330, 60, 350, 60, 80, 60, 340};

		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			load_config(phase_roots[phase], phase_spaces[phase]);
			target = sent + phase_items[phase];
			while (sent < target) begin
				// hold off once mid-phase until the block has caught up
				if (phase == PRESSURE_PHASE && !paused && target - sent < phase_items[phase] / 2) begin
					drain_results();
					paused = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (r < 22) begin
					if (mapped_vas.size() != 0 && $urandom_range(0, 2) == 0) begin
						va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
					end else begin
						// small indexes mostly so that paths share tables
						va = '0;
						va[46:39] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
							8'($urandom_range(0, 5));
						va[38:30] = ($urandom_range(0, 3) == 0) ? 9'($urandom) :
							9'($urandom_range(0, 5));
						va[29:21] = ($urandom_range(0, 3) == 0) ? 9'($urandom) :
							9'($urandom_range(0, 5));
						va[20:12] = ($urandom_range(0, 3) == 0) ? 9'($urandom) :
							9'($urandom_range(0, 5));
					end
					map_walk_path(va);
				end else if (r < 80) begin
					walk_op(1'b0);
				end else if (r < 88) begin
					send_item(KIND_READ, {$urandom, $urandom},
						$urandom_range(0, 1) ? 15'($urandom) :
						15'($urandom_range(1, TABLE_PAGES - 1) * 512 + $urandom_range(0, 7)),
						{$urandom, $urandom});
				end else if (r < 93) begin
					send_item(KIND_WRITE, {$urandom, $urandom}, 15'($urandom),
						{$urandom, $urandom});
				end else if (r < 96) begin
					send_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
						{$urandom, $urandom}, 15'($urandom), {$urandom, $urandom});
				end else begin
					walk_op(1'b1);
				end
			end
		end

		// wind down and report
		start <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("tb_four_level_page_table_walker: PASS");
		else
			$display("tb_four_level_page_table_walker: FAIL");
		$finish;
	end

endmodule
